// File: sv/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, codes and constant tables for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ita_pkg;

  localparam logic [2:0] OP_UDEC    = 3'd0;
  localparam logic [2:0] OP_SDEC    = 3'd1;
  localparam logic [2:0] OP_HEX_LO  = 3'd2;
  localparam logic [2:0] OP_HEX_UP  = 3'd3;
  localparam logic [2:0] OP_POINTER = 3'd4;
  localparam logic [2:0] OP_CHAR    = 3'd5;
  localparam logic [2:0] OP_PERCENT = 3'd6;

  localparam logic [1:0] KIND_DEC = 2'd0;
  localparam logic [1:0] KIND_HEX = 2'd1;
  localparam logic [1:0] KIND_ONE = 2'd2;

  localparam logic [4:0] DEC_POS_MAX = 5'd19;
  localparam logic [4:0] HEX_POS_MAX = 5'd15;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_A_LO    = 8'h61;
  localparam logic [7:0] CH_A_UP    = 8'h41;

  typedef struct packed {
    logic [1:0]  kind;
    logic        caps;
    logic [1:0]  pre_cnt;
    logic        pre_hex;
    logic [63:0] mag;
  } cmd_t;

  function automatic logic [63:0] pow10(input logic [4:0] idx);
    logic [63:0] p;
    unique case (idx)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic caps);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'b0000, nib};
    end else begin
      c = (caps ? CH_A_UP : CH_A_LO) + {4'b0000, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style integer conversion (dec, hex, pointer, char, percent) that
// streams the ASCII text one character per output item, last one marked.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   in      | in_valid in_stall in_opcode in_wide | input
//           | in_value                            |
//   out     | out_valid out_stall out_char        | output
//           | out_last                            |
//
// The digit engine does one position per cycle unless out_stall holds it;
// positions: decimal 20 (+1 minus), hex 16, pointer 2 + 16, char/percent 1.
// Requests queue ahead of the engine, so input is taken while it works.
// Synchronous active-low reset; no clearing pass.
// out_stall only holds the engine when a character must be written.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [2:0]   in_opcode,
  input  wire logic         in_wide,
  input  wire logic [63:0]  in_value,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_char,
  output logic              out_last
);
  import ita_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic q_full, q_push, q_valid, q_pop;

  ita_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_wide   (in_wide),
    .in_value  (in_value),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  ita_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd)
  );

  ita_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

// File: sv/ita_front.sv
// ----------------------------------------------------------------------------
// ita_front
// Input handshake and request classification: picks the working value,
// sign prefix and digit engine for each request.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_front (
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [2:0]   in_opcode,
  input  wire logic         in_wide,
  input  wire logic [63:0]  in_value,
  input  wire logic         q_full,
  output logic              q_push,
  output ita_pkg::cmd_t     q_cmd
);
  import ita_pkg::*;

  logic [63:0] v_sel;
  logic [63:0] v_sext;
  logic        neg;
  logic        op_ok;

  assign in_stall = q_full;

  always_comb begin
    v_sel  = in_wide ? in_value : {32'd0, in_value[31:0]};
    neg    = in_wide ? in_value[63] : in_value[31];
    v_sext = in_wide ? in_value : {{32{in_value[31]}}, in_value[31:0]};
    op_ok  = 1'b1;
    q_cmd  = '0;
    unique case (in_opcode)
      OP_UDEC: begin
        q_cmd.kind = KIND_DEC;
        q_cmd.mag  = v_sel;
      end
      OP_SDEC: begin
        q_cmd.kind    = KIND_DEC;
        q_cmd.pre_cnt = neg ? 2'd1 : 2'd0;
        q_cmd.mag     = neg ? (64'd0 - v_sext) : v_sel;
      end
      OP_HEX_LO: begin
        q_cmd.kind = KIND_HEX;
        q_cmd.mag  = v_sel;
      end
      OP_HEX_UP: begin
        q_cmd.kind = KIND_HEX;
        q_cmd.caps = 1'b1;
        q_cmd.mag  = v_sel;
      end
      OP_POINTER: begin
        q_cmd.kind    = KIND_HEX;
        q_cmd.pre_cnt = 2'd2;
        q_cmd.pre_hex = 1'b1;
        q_cmd.mag     = in_value;
      end
      OP_CHAR: begin
        q_cmd.kind = KIND_ONE;
        q_cmd.mag  = {56'd0, in_value[7:0]};
      end
      OP_PERCENT: begin
        q_cmd.kind = KIND_ONE;
        q_cmd.mag  = {56'd0, CH_PERCENT};
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // unused opcode: item taken, nothing queued
  assign q_push = in_valid && !q_full && op_ok;

endmodule

`default_nettype wire

// File: sv/ita_queue.sv
// ----------------------------------------------------------------------------
// ita_queue
// Short command queue between the classifier and the digit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ita_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               pop_valid,
  input  wire logic          pop,
  output ita_pkg::cmd_t      pop_cmd
);
  import ita_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count out of range");

endmodule

`default_nettype wire

// File: sv/ita_back.sv
// ----------------------------------------------------------------------------
// ita_back
// Digit engine: prefix characters, one decimal or hex position per cycle
// unless stalled, with leading-zero suppression; and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire ita_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_char,
  output logic               out_last
);
  import ita_pkg::*;

  logic        busy_r, busy_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        caps_r, caps_nxt;
  logic [1:0]  pre_cnt_r, pre_cnt_nxt;
  logic        pre_hex_r, pre_hex_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        started_r, started_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic [63:0] pow;
  logic [67:0] mult [10];
  logic [3:0]  dig;
  logic [3:0]  nib;
  logic        emit, last_c, slot_free, step, finish, load_cmd;
  logic [7:0]  ch;

  // one decimal digit: largest k with k*10^pos <= rem
  always_comb begin
    pow = pow10(pos_r);
    dig = 4'd0;
    for (int k = 0; k < 10; k++) begin
      mult[k] = {4'b0000, pow} * 68'(k);
    end
    for (int k = 1; k < 10; k++) begin
      if ({4'b0000, rem_r} >= mult[k]) begin
        dig = 4'(k);
      end
    end
  end

  assign nib = rem_r[63:60];

  always_comb begin
    emit   = 1'b1;
    last_c = 1'b0;
    ch     = CH_ZERO;
    if (pre_cnt_r != 2'd0) begin
      ch = pre_hex_r ? ((pre_cnt_r == 2'd2) ? CH_ZERO : CH_X) : CH_MINUS;
    end else begin
      unique case (kind_r)
        KIND_DEC: begin
          emit   = started_r || (dig != 4'd0) || (pos_r == 5'd0);
          last_c = (pos_r == 5'd0);
          ch     = CH_ZERO + {4'b0000, dig};
        end
        KIND_HEX: begin
          emit   = started_r || (nib != 4'd0) || (pos_r == 5'd0);
          last_c = (pos_r == 5'd0);
          ch     = hex_char(nib, caps_r);
        end
        KIND_ONE: begin
          last_c = 1'b1;
          ch     = rem_r[7:0];
        end
        default: begin
          emit   = 1'b0;
          last_c = 1'b1;
        end
      endcase
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign step      = busy_r && (!emit || slot_free);
  assign finish    = step && last_c;
  assign load_cmd  = q_valid && (!busy_r || finish);
  assign q_pop     = load_cmd;

  always_comb begin
    busy_nxt    = busy_r;
    kind_nxt    = kind_r;
    caps_nxt    = caps_r;
    pre_cnt_nxt = pre_cnt_r;
    pre_hex_nxt = pre_hex_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    rem_nxt     = rem_r;
    if (load_cmd) begin
      busy_nxt    = 1'b1;
      kind_nxt    = q_cmd.kind;
      caps_nxt    = q_cmd.caps;
      pre_cnt_nxt = q_cmd.pre_cnt;
      pre_hex_nxt = q_cmd.pre_hex;
      pos_nxt     = (q_cmd.kind == KIND_HEX) ? HEX_POS_MAX : DEC_POS_MAX;
      started_nxt = 1'b0;
      rem_nxt     = q_cmd.mag;
    end else if (step) begin
      if (pre_cnt_r != 2'd0) begin
        pre_cnt_nxt = pre_cnt_r - 2'd1;
      end else begin
        busy_nxt    = !finish;
        pos_nxt     = pos_r - 5'd1;
        started_nxt = started_r || emit;
        if (kind_r == KIND_DEC) begin
          rem_nxt = rem_r - mult[dig][63:0];
        end else if (kind_r == KIND_HEX) begin
          rem_nxt = {rem_r[59:0], 4'h0};
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ch;
      out_last_nxt  = last_c;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    caps_r     <= caps_nxt;
    pre_cnt_r  <= pre_cnt_nxt;
    pre_hex_r  <= pre_hex_nxt;
    pos_r      <= pos_nxt;
    started_r  <= started_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  a_one_no_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && kind_r == KIND_ONE) |-> (pre_cnt_r == 2'd0))
    else $error("single char with prefix");

  a_dec_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && kind_r == KIND_DEC && pos_r != DEC_POS_MAX && pos_r <= DEC_POS_MAX)
      |-> ({4'b0000, rem_r} < mult[1] * 68'd10))
    else $error("decimal remainder exceeds position");

  a_hex_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && kind_r == KIND_HEX) |-> (pos_r <= HEX_POS_MAX))
    else $error("hex position out of range");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: integer to ASCII formatter testbench
// Drives conversion requests with bursty gaps while the receiver stalls in
// changing patterns, once for a long stretch. The expected text of each
// request is formatted here and every character and last mark is compared
// in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ita_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  class ascii_scoreboard;
    text_char_t  expected_text[$];
    logic [7:0]  line_buf[$];
    int          mismatches;
    int          chars_checked;
    int          per_op[8];

    task report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    function void add_decimal(input logic [63:0] v);
      logic [7:0]  digits[$];
      logic [63:0] r;
      do begin
        r = v % 64'd10;
        digits.push_front(CH_ZERO + r[7:0]);
        v = v / 64'd10;
      end while (v != 64'd0);
      foreach (digits[i]) line_buf.push_back(digits[i]);
    endfunction

    function void add_hex(input logic [63:0] v, input logic caps);
      string      set;
      logic       started;
      logic [3:0] d;
      set = caps ? "0123456789ABCDEF" : "0123456789abcdef";
      started = 1'b0;
      for (int sh = 60; sh >= 0; sh -= 4) begin
        d = v[sh +: 4];
        if (d != 4'd0 || sh == 0) started = 1'b1;
        if (started) line_buf.push_back(set[d]);
      end
    endfunction

    function void note_request(input logic [2:0] op, input logic wide,
                               input logic [63:0] raw);
      logic [63:0] v;
      logic        neg;
      line_buf.delete();
      per_op[op]++;
      v = wide ? raw : {32'd0, raw[31:0]};
      case (op)
        OP_UDEC: add_decimal(v);
        OP_SDEC: begin
          neg = wide ? raw[63] : raw[31];
          if (!wide && neg) v = {32'hFFFF_FFFF, raw[31:0]};
          if (neg) begin
            line_buf.push_back(CH_MINUS);
            v = 64'd0 - v;
          end
          add_decimal(v);
        end
        OP_HEX_LO: add_hex(v, 1'b0);
        OP_HEX_UP: add_hex(v, 1'b1);
        OP_POINTER: begin
          line_buf.push_back(CH_ZERO);
          line_buf.push_back(CH_X);
          add_hex(raw, 1'b0);
        end
        OP_CHAR:    line_buf.push_back(raw[7:0]);
        OP_PERCENT: line_buf.push_back(CH_PERCENT);
        default: ;
      endcase
      foreach (line_buf[i])
        expected_text.push_back('{ch: line_buf[i], last: (i == line_buf.size() - 1)});
    endfunction

    task check_result(input logic [7:0] ch, input logic last);
      text_char_t e;
      chars_checked++;
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b", ch, last));
      end else begin
        e = expected_text.pop_front();
        if (ch !== e.ch)
          report_mismatch($sformatf("char 0x%02h, expected 0x%02h", ch, e.ch));
        if (last !== e.last)
          report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                    last, e.last, e.ch));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = OP_UDEC;
  logic        in_wide = 1'b0;
  logic [63:0] in_value = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        out_last;

  ascii_scoreboard sb = new();
  bit  hold_req = 1'b0;
  int  cycles = 0;
  int  ignored = 0;

  integer_to_ascii_formatter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_wide   (in_wide),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_char, out_last);
  end

  // receiver: stall patterns in random stretches, one long hold-off on request
  initial begin : receiver
    int mode;
    int stretch;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(10, 150);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // call right after a rising edge; returns at the edge that accepted the item
  task automatic send_request(input logic [2:0] op, input logic wide,
                              input logic [63:0] val);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_wide   <= wide;
    in_value  <= val;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, wide, val);
    if (op == OP_UNUSED) ignored++;
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = 64'd0 - (v >> $urandom_range(32, 63));
      2: v = {v[63:32], 32'd0 - (v[31:0] >> $urandom_range(0, 31))};
      3: v = 64'($urandom_range(0, 20));
      default: ;
    endcase
    return v;
  endfunction

  initial begin : sender
    int          sent;
    int          burst;
    logic [2:0]  op;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_UDEC,    1'b1, 64'd0);
    send_request(OP_UDEC,    1'b0, 64'hA5A5_A5A5_FFFF_FFFF);
    send_request(OP_UDEC,    1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_UDEC,    1'b1, 64'd10000000000000000000);
    send_request(OP_SDEC,    1'b0, 64'h1234_5678_8000_0000);
    send_request(OP_SDEC,    1'b0, 64'h0000_0000_FFFF_FFFF);
    send_request(OP_SDEC,    1'b0, 64'hFFFF_FFFF_7FFF_FFFF);
    send_request(OP_SDEC,    1'b1, 64'h8000_0000_0000_0000);
    send_request(OP_SDEC,    1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_SDEC,    1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(OP_SDEC,    1'b1, 64'd0);
    send_request(OP_HEX_LO,  1'b0, 64'hFFFF_FFFF_0000_0000);
    send_request(OP_HEX_LO,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_HEX_LO,  1'b0, 64'h0123_4567_DEAD_BEEF);
    send_request(OP_HEX_UP,  1'b1, 64'hABCD_EF01_2345_6789);
    send_request(OP_HEX_UP,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_POINTER, 1'b0, 64'hFFFF_FFFF_0000_0000);
    send_request(OP_POINTER, 1'b1, 64'd0);
    send_request(OP_CHAR,    1'b1, 64'h0000_0000_0000_00FF);
    send_request(OP_CHAR,    1'b0, 64'hFFFF_FFFF_FFFF_FF00);
    send_request(OP_PERCENT, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_UNUSED,  1'b0, 64'h0123_4567_89AB_CDEF);
    send_request(OP_PERCENT, 1'b0, 64'd0);
    send_request(OP_UNUSED,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    idle_for($urandom_range(1, 5));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
      repeat (burst) begin
        op = ($urandom_range(0, 31) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
        send_request(op, 1'($urandom), random_value());
        if (op != OP_UNUSED) sent++;
        if (sent == RANDOM_ITEMS / 2) hold_req = 1'b1;
      end
      idle_for($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 25));
    end
    in_valid <= 1'b0;

    while (sb.expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d unused-opcode), %0d characters checked",
             sb.per_op.sum(), ignored, sb.chars_checked);
    $display("kinds: udec %0d sdec %0d hex %0d HEX %0d ptr %0d char %0d pct %0d",
             sb.per_op[OP_UDEC], sb.per_op[OP_SDEC], sb.per_op[OP_HEX_LO],
             sb.per_op[OP_HEX_UP], sb.per_op[OP_POINTER], sb.per_op[OP_CHAR],
             sb.per_op[OP_PERCENT]);
    if (sb.mismatches == 0 && sb.expected_text.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d characters never seen",
               sb.mismatches, sb.expected_text.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
